// ===== sv/drank_pkg.sv =====
package drank_pkg;

  // Fixed field widths of the item and result payloads.
  localparam int SCORE_W = 16;
  localparam int IDX_W   = 4;
  localparam int RANK_W  = 5;

  // One input item: a signed Q3.12 score and the end-of-set mark.
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      last_score;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [IDX_W-1:0]  item_index;
    logic [RANK_W-1:0] rank;
    logic              overflow;
    logic              last_result;
  } result_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RANK,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic rank_wr;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic set_end;
    logic step_last;
  } ctrl_status_t;

endpackage

// ===== sv/drank_ctrl.sv =====
module drank_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  drank_pkg::ctrl_status_t status_i,
  output drank_pkg::ctrl_cmd_t    cmd_o,
  output logic                    busy_o
);
  import drank_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RANK;
        end
      end
      ST_RANK: begin
        // Finish the rank of the score just stored.
        cmd_o.rank_wr = 1'b1;
        state_d       = status_i.set_end ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        // Issue one result per cycle until the set is done.
        cmd_o.emit = 1'b1;
        if (status_i.step_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/drank_dp.sv =====
module drank_dp #(
  parameter int MAX_ITEMS  = 16,
  parameter int SCORE_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  drank_pkg::ctrl_cmd_t    cmd_i,
  output drank_pkg::ctrl_status_t status_o,
  input  drank_pkg::in_item_t     in_item_i,
  input  logic                    cfg_we_i,
  input  logic                    cfg_data_i,
  output drank_pkg::result_t      result_o,
  output logic                    result_valid_o
);
  import drank_pkg::*;

  localparam int IW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int NG = (MAX_ITEMS + 7) / 8;
  localparam int GW = 4;

  // Row of cells: one score and one running rank per stored entry.
  logic signed [SCORE_BITS-1:0] score_q [MAX_ITEMS];
  logic [CW-1:0]                rank_q  [MAX_ITEMS];

  logic [CW-1:0] count_q;
  logic          dropped_q;
  logic          last_q;
  logic          pend_wr_q;
  logic [IW-1:0] pend_idx_q;
  logic [IW-1:0] step_q;
  logic          order_q;
  logic [GW-1:0] grp_q [NG];
  logic [GW-1:0] grp_d [NG];

  logic signed [SCORE_BITS-1:0] new_score;
  logic [MAX_ITEMS-1:0]         occupied;
  logic [MAX_ITEMS-1:0]         beats;
  logic [MAX_ITEMS-1:0]         ge;
  logic [NG*8-1:0]              ge_pad;
  logic                         room;
  logic                         store_en;
  logic [CW-1:0]                pop_sum;
  logic [CW-1:0]                new_rank;
  logic                         step_last;

  logic [MAX_ITEMS-1:0] match;
  logic [MAX_ITEMS-1:0] sel_q;
  logic                 sel_vld_q;
  logic                 sel_last_q;
  logic                 sel_ovf_q;
  logic [IW-1:0]        idx_or;
  logic [CW-1:0]        rank_or;
  logic [IDX_W+IW-1:0]  idx_ext;
  logic [RANK_W+CW-1:0] rank_ext;
  result_t              result_q;
  logic                 result_vld_q;

  // Bring the score field to the internal score width.
  if (SCORE_BITS <= SCORE_W) begin : g_narrow
    assign new_score = in_item_i.score[SCORE_BITS-1:0];
  end else begin : g_wide
    assign new_score = SCORE_BITS'(in_item_i.score);
  end

  assign room     = (count_q < CW'(MAX_ITEMS));
  assign store_en = cmd_i.load && room;

  // Compare the arriving score against every stored cell in parallel.
  always_comb begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      occupied[i] = (CW'(i) < count_q);
      beats[i]    = occupied[i] && (new_score > score_q[i]);
      ge[i]       = occupied[i] && (score_q[i] >= new_score);
    end
  end

  // Partial counts of cells scoring at or above the new score, eight per group.
  assign ge_pad = (NG*8)'(ge);
  always_comb begin
    logic [GW-1:0] cnt;
    for (int g = 0; g < NG; g++) begin
      cnt = '0;
      for (int b = 0; b < 8; b++) begin
        cnt = cnt + GW'(ge_pad[g*8+b]);
      end
      grp_d[g] = cnt;
    end
  end

  // Sum of the group counts plus one gives the rank of the new entry.
  always_comb begin
    pop_sum = '0;
    for (int g = 0; g < NG; g++) begin
      pop_sum = pop_sum + CW'(grp_q[g]);
    end
  end
  assign new_rank = pop_sum + 1'b1;

  // Cell storage: write the new score, bump outranked cells, set the new rank.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      if (store_en && (CW'(i) == count_q)) begin
        score_q[i] <= new_score;
      end
      if (store_en && beats[i]) begin
        rank_q[i] <= rank_q[i] + 1'b1;
      end else if (cmd_i.rank_wr && pend_wr_q && (IW'(i) == pend_idx_q)) begin
        rank_q[i] <= new_rank;
      end
    end
    if (cmd_i.load) begin
      grp_q <= grp_d;
    end
  end

  assign step_last = (CW'(step_q) == (count_q - 1'b1));

  // Set bookkeeping and the configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      dropped_q  <= 1'b0;
      last_q     <= 1'b0;
      pend_wr_q  <= 1'b0;
      pend_idx_q <= '0;
      step_q     <= '0;
      order_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        order_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        pend_wr_q  <= room;
        pend_idx_q <= count_q[IW-1:0];
        last_q     <= in_item_i.last_score;
        if (room) begin
          count_q <= count_q + 1'b1;
        end else begin
          dropped_q <= 1'b1;
        end
      end
      if (cmd_i.emit) begin
        if (step_last) begin
          step_q    <= '0;
          count_q   <= '0;
          dropped_q <= 1'b0;
          last_q    <= 1'b0;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
    end
  end

  assign status_o.set_end   = last_q;
  assign status_o.step_last = step_last;

  // Pick the cell for this output step: by position or by rank.
  always_comb begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      match[i] = occupied[i] &&
                 (order_q ? (rank_q[i] == (CW'(step_q) + 1'b1)) : (IW'(i) == step_q));
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q      <= match;
    sel_last_q <= step_last;
    sel_ovf_q  <= dropped_q;
  end

  // Collapse the one-hot selection into index and rank.
  always_comb begin
    idx_or  = '0;
    rank_or = '0;
    for (int i = 0; i < MAX_ITEMS; i++) begin
      if (sel_q[i]) begin
        idx_or  = idx_or | IW'(i);
        rank_or = rank_or | rank_q[i];
      end
    end
  end

  assign idx_ext  = {{IDX_W{1'b0}}, idx_or};
  assign rank_ext = {{RANK_W{1'b0}}, rank_or};

  always_ff @(posedge clk_i) begin
    result_q.item_index  <= idx_ext[IDX_W-1:0];
    result_q.rank        <= rank_ext[RANK_W-1:0];
    result_q.overflow    <= sel_ovf_q;
    result_q.last_result <= sel_last_q;
  end

  // Result strobe pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_vld_q    <= 1'b0;
      result_vld_q <= 1'b0;
    end else begin
      sel_vld_q    <= cmd_i.emit;
      result_vld_q <= sel_vld_q;
    end
  end

  assign result_o       = result_q;
  assign result_valid_o = result_vld_q;

endmodule

// ===== sv/descending_rank_engine.sv =====
// Loading: a score is stored, then ranked by summing the compare counts from
// the parallel cell row; busy is high for one cycle after start, except for the
// last score. After the last score, n results follow one per cycle via the
// selection and result registers; busy falls in the cycle before the last
// result appears. Results cannot be stalled. Reset (rst_ni low, asynchronous)
// empties the set, clears the overflow flag and sets output_order to input order.
module descending_rank_engine #(
  parameter int MAX_ITEMS  = 16,
  parameter int SCORE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  drank_pkg::in_item_t in_item_i,
  input  logic                cfg_we_i,
  input  logic                cfg_data_i,
  output drank_pkg::result_t  result_o,
  output logic                result_valid_o
);
  import drank_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // Sequencer for load, rank and output phases.
  drank_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  // Score cells, rank counters and result pipeline.
  drank_dp #(
    .MAX_ITEMS  (MAX_ITEMS),
    .SCORE_BITS (SCORE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .in_item_i      (in_item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

  // An accepted item always occupies the rank cycle.
  a_rank_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("no rank cycle after an accepted item");

  // Each result comes from an output step via the select and result registers.
  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(cmd.emit, 2))
    else $error("result without an issued output step");

  // A new set cannot produce a result right after the last one.
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last_result) |=> !result_valid_o)
    else $error("result directly after the final result of a set");

  // The final output step returns the controller to idle.
  a_idle_after_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && status.step_last) |=> !busy)
    else $error("still busy after the final output step");

endmodule
